/* sv/tpp_pkg.sv */
// Shared types and constants for the thick polyline pixel test block.
// Has no dependencies; every other file of the block imports it.
package tpp_pkg;

  // Grid coordinate width of a stored point.
  localparam int PT_W   = 6;
  // Output pixel coordinate width.
  localparam int PIX_W  = 10;
  // Configuration register widths.
  localparam int GRID_W = 7;
  localparam int SCL_W  = 5;
  localparam int THK_W  = 12;
  localparam int CFG_W  = 12;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_THICKNESS = 2'd2;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef struct packed {
    logic [1:0]       operation;
    logic [PT_W-1:0]  point_x;
    logic [PT_W-1:0]  point_y;
    logic             starts_stroke;
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic drawn;
    logic in_range;
  } out_item_t;

  // One entry of the point store.
  typedef struct packed {
    logic            starts_stroke;
    logic [PT_W-1:0] y;
    logic [PT_W-1:0] x;
  } pt_entry_t;

  // Operation issued to the shared multiply-accumulate unit.
  typedef enum logic [3:0] {
    U_NOP,
    U_LIM,
    U_T2,
    U_CX,
    U_CY,
    U_DX,
    U_DY,
    U_DOT1,
    U_DOT2,
    U_LEN1,
    U_LEN2,
    U_CR1,
    U_CR2,
    U_SQ,
    U_TL,
    U_SHIFT
  } uop_t;

  // Compare results from the datapath back to the sequencer.
  typedef struct packed {
    logic in_range;
    logic near_pt;
    logic seg_ok;
    logic seg_hit;
  } flags_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LIM,
    S_RANGE,
    S_T2,
    S_RD,
    S_CX,
    S_CY,
    S_DX,
    S_DY,
    S_PTCHK,
    S_DOT1,
    S_DOT2,
    S_LEN1,
    S_LEN2,
    S_SEGCHK,
    S_CR1,
    S_CR2,
    S_SQ,
    S_TL,
    S_HITCHK,
    S_NEXT
  } state_t;

endpackage

/* sv/tpp_store.sv */
// Point store: memory of loaded points and the point count.
// Depends on tpp_pkg.
module tpp_store #(
  parameter int MAX_POINTS = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic [1:0]                          operation,
  input  logic [tpp_pkg::PT_W-1:0]            point_x,
  input  logic [tpp_pkg::PT_W-1:0]            point_y,
  input  logic                                starts_stroke,
  input  logic [$clog2(MAX_POINTS+1)-1:0]     rd_idx,
  output tpp_pkg::pt_entry_t                  rd_entry,
  output logic [$clog2(MAX_POINTS+1)-1:0]     cnt
);
  import tpp_pkg::*;

  localparam int CNW = $clog2(MAX_POINTS + 1);
  localparam int PA  = $clog2(MAX_POINTS);

  pt_entry_t        mem [MAX_POINTS];
  pt_entry_t        rd_entry_r;
  logic [CNW-1:0]   cnt_r;
  logic             load_ok;

  assign load_ok = accept && (operation == OP_LOAD) && (cnt_r < CNW'(MAX_POINTS));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (accept && (operation == OP_CLEAR)) begin
      cnt_r <= '0;
    end else if (load_ok) begin
      cnt_r <= cnt_r + CNW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      mem[cnt_r[PA-1:0]] <= '{starts_stroke: starts_stroke, y: point_y, x: point_x};
    end
  end

  always_ff @(posedge clk) begin
    rd_entry_r <= mem[rd_idx[PA-1:0]];
  end

  assign rd_entry = rd_entry_r;
  assign cnt      = cnt_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNW'(MAX_POINTS))
    else $error("point count beyond capacity");

  a_cnt_load: assert property (@(posedge clk) disable iff (!rst_n)
    load_ok |=> cnt_r == $past(cnt_r) + CNW'(1))
    else $error("accepted load did not advance the count");

endmodule

/* sv/tpp_dpath.sv */
// Datapath: the shared multiply-accumulate unit with its operand registers.
// Depends on tpp_pkg.
module tpp_dpath #(
  parameter int MAX_GRID  = 64,
  parameter int MAX_SCALE = 16
) (
  input  logic                                clk,
  input  logic                                capture,
  input  logic [tpp_pkg::PIX_W-1:0]           pixel_x,
  input  logic [tpp_pkg::PIX_W-1:0]           pixel_y,
  input  logic [$clog2(MAX_GRID+1)-1:0]       g,
  input  logic [$clog2(MAX_SCALE+1)-1:0]      s,
  input  logic [tpp_pkg::THK_W-1:0]           thickness,
  input  tpp_pkg::pt_entry_t                  rd_entry,
  input  tpp_pkg::uop_t                       uop,
  output tpp_pkg::flags_t                     flags
);
  import tpp_pkg::*;

  localparam int LW   = $clog2(MAX_GRID * MAX_SCALE + 1);
  localparam int CTOP = 2 * 63 * MAX_SCALE + MAX_SCALE;
  localparam int CMAX = (CTOP > 2047) ? CTOP : 2047;
  localparam int CW   = $clog2(CMAX + 1);
  localparam int DW   = CW + 2;
  localparam int OW   = 2 * DW + 1;
  localparam int AW   = 2 * OW + 6;

  logic [PIX_W-1:0]        pix_x_r, pix_y_r;
  logic [LW-1:0]           lim_r;
  logic signed [OW-1:0]    t2_r, dot_r, len_r, cr_r;
  logic signed [AW-1:0]    sq_r, acc_r;
  logic signed [DW-1:0]    ax_r, ay_r, bx_r, by_r;

  logic signed [DW-1:0]    qx, qy, off, vx, vy, cx, cy, dx, dy;
  logic signed [OW-1:0]    opa, opb;
  logic signed [AW-1:0]    addend, mac_res;
  logic signed [2*OW-1:0]  prod;
  logic                    neg, acc_we;

  assign qx  = DW'({pix_x_r, 1'b0});
  assign qy  = DW'({pix_y_r, 1'b0});
  assign off = $signed(DW'({(s >> 1), 1'b0})) - $signed(DW'(1));
  assign vx  = qx - bx_r;
  assign vy  = qy - by_r;
  assign cx  = ax_r - bx_r;
  assign cy  = ay_r - by_r;
  assign dx  = qx - ax_r;
  assign dy  = qy - ay_r;

  // Operand selection for the shared unit.
  always_comb begin
    opa    = '0;
    opb    = '0;
    addend = '0;
    neg    = 1'b0;
    acc_we = 1'b1;
    unique case (uop)
      U_LIM:  begin opa = OW'(g);           opb = OW'(s);            end
      U_T2:   begin opa = OW'(thickness);   opb = OW'(thickness);    end
      U_CX:   begin
        opa = OW'(rd_entry.x); opb = OW'({s, 1'b0}); addend = AW'(off);
      end
      U_CY:   begin
        opa = OW'(rd_entry.y); opb = OW'({s, 1'b0}); addend = AW'(off);
      end
      U_DX:   begin opa = OW'(dx); opb = OW'(dx);                    end
      U_DY:   begin opa = OW'(dy); opb = OW'(dy); addend = acc_r;    end
      U_DOT1: begin opa = OW'(vx); opb = OW'(cx);                    end
      U_DOT2: begin opa = OW'(vy); opb = OW'(cy); addend = acc_r;    end
      U_LEN1: begin opa = OW'(cx); opb = OW'(cx);                    end
      U_LEN2: begin opa = OW'(cy); opb = OW'(cy); addend = acc_r;    end
      U_CR1:  begin opa = OW'(vx); opb = OW'(cy);                    end
      U_CR2:  begin
        opa = OW'(vy); opb = OW'(cx); addend = acc_r; neg = 1'b1;
      end
      U_SQ:   begin opa = cr_r; opb = cr_r;                          end
      U_TL:   begin opa = t2_r; opb = len_r;                         end
      U_NOP, U_SHIFT: begin acc_we = 1'b0;                           end
      default: begin acc_we = 1'b0;                                  end
    endcase
  end

  assign prod    = opa * opb;
  assign mac_res = neg ? (addend - AW'(prod)) : (addend + AW'(prod));

  always_ff @(posedge clk) begin
    if (capture) begin
      pix_x_r <= pixel_x;
      pix_y_r <= pixel_y;
    end
    if (acc_we) begin
      acc_r <= mac_res;
    end
    unique case (uop)
      U_LIM:   lim_r <= LW'(mac_res);
      U_T2:    t2_r  <= OW'(mac_res);
      U_CX:    ax_r  <= DW'(mac_res);
      U_CY:    ay_r  <= DW'(mac_res);
      U_DOT2:  dot_r <= OW'(mac_res);
      U_LEN2:  len_r <= OW'(mac_res);
      U_CR2:   cr_r  <= OW'(mac_res);
      U_SQ:    sq_r  <= mac_res;
      U_SHIFT: begin
        bx_r <= ax_r;
        by_r <= ay_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    flags.in_range = (32'(pix_x_r) < 32'(lim_r)) && (32'(pix_y_r) < 32'(lim_r));
    flags.near_pt  = (acc_r <<< 6) <= AW'(t2_r);
    flags.seg_ok   = (len_r != '0) && !dot_r[OW-1] && (dot_r != '0) && (dot_r < len_r);
    flags.seg_hit  = (sq_r <<< 6) <= acc_r;
  end

endmodule

/* sv/tpp_seq.sv */
// Sequencer: walks the stored points for a query and drives the shared unit.
// Depends on tpp_pkg.
module tpp_seq #(
  parameter int MAX_POINTS = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic [1:0]                          operation,
  input  logic [$clog2(MAX_POINTS+1)-1:0]     cnt,
  input  logic                                rd_mark,
  input  tpp_pkg::flags_t                     flags,
  output logic                                busy,
  output logic                                capture,
  output logic [$clog2(MAX_POINTS+1)-1:0]     idx,
  output tpp_pkg::uop_t                       uop,
  output logic                                out_strobe,
  output tpp_pkg::out_item_t                  out_data
);
  import tpp_pkg::*;

  localparam int CNW = $clog2(MAX_POINTS + 1);

  state_t          state_r, state_nxt;
  logic [CNW-1:0]  idx_r;
  logic            out_strobe_r, out_drawn_r, out_range_r;
  logic            finish, fin_drawn, fin_range;

  assign busy    = (state_r != S_IDLE);
  assign capture = start && !busy && (operation == OP_QUERY);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (capture) begin state_nxt = S_LIM; end
      S_LIM:    state_nxt = S_RANGE;
      S_RANGE:  state_nxt = flags.in_range ? S_T2 : S_IDLE;
      S_T2:     state_nxt = S_RD;
      S_RD:     state_nxt = (idx_r == cnt) ? S_IDLE : S_CX;
      S_CX:     state_nxt = S_CY;
      S_CY:     state_nxt = S_DX;
      S_DX:     state_nxt = S_DY;
      S_DY:     state_nxt = S_PTCHK;
      S_PTCHK: begin
        priority if (flags.near_pt) begin
          state_nxt = S_IDLE;
        end else if ((idx_r != '0) && !rd_mark) begin
          state_nxt = S_DOT1;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_DOT1:   state_nxt = S_DOT2;
      S_DOT2:   state_nxt = S_LEN1;
      S_LEN1:   state_nxt = S_LEN2;
      S_LEN2:   state_nxt = S_SEGCHK;
      S_SEGCHK: state_nxt = flags.seg_ok ? S_CR1 : S_NEXT;
      S_CR1:    state_nxt = S_CR2;
      S_CR2:    state_nxt = S_SQ;
      S_SQ:     state_nxt = S_TL;
      S_TL:     state_nxt = S_HITCHK;
      S_HITCHK: state_nxt = flags.seg_hit ? S_IDLE : S_NEXT;
      S_NEXT:   state_nxt = S_RD;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    uop       = U_NOP;
    finish    = 1'b0;
    fin_drawn = 1'b0;
    fin_range = 1'b1;
    unique case (state_r)
      S_LIM:    uop = U_LIM;
      S_RANGE: begin
        finish    = !flags.in_range;
        fin_range = 1'b0;
      end
      S_T2:     uop = U_T2;
      S_RD:     finish = (idx_r == cnt);
      S_CX:     uop = U_CX;
      S_CY:     uop = U_CY;
      S_DX:     uop = U_DX;
      S_DY:     uop = U_DY;
      S_PTCHK: begin
        finish    = flags.near_pt;
        fin_drawn = 1'b1;
      end
      S_DOT1:   uop = U_DOT1;
      S_DOT2:   uop = U_DOT2;
      S_LEN1:   uop = U_LEN1;
      S_LEN2:   uop = U_LEN2;
      S_CR1:    uop = U_CR1;
      S_CR2:    uop = U_CR2;
      S_SQ:     uop = U_SQ;
      S_TL:     uop = U_TL;
      S_HITCHK: begin
        finish    = flags.seg_hit;
        fin_drawn = 1'b1;
      end
      S_NEXT:   uop = U_SHIFT;
      S_IDLE, S_SEGCHK: ;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      idx_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= finish;
      if (capture) begin
        idx_r <= '0;
      end else if (state_r == S_NEXT) begin
        idx_r <= idx_r + CNW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_drawn_r <= fin_drawn;
      out_range_r <= fin_range;
    end
  end

  assign idx              = idx_r;
  assign out_strobe       = out_strobe_r;
  assign out_data.drawn    = out_drawn_r;
  assign out_data.in_range = out_range_r;

  a_no_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |=> !out_strobe_r)
    else $error("result strobe without a query in progress");

  a_drawn_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && !out_range_r |-> !out_drawn_r)
    else $error("out of range pixel reported as drawn");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy && (state_r != S_LIM) && (state_r != S_RANGE) && (state_r != S_T2)
      |-> idx_r <= cnt)
    else $error("point index ran past the point count");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> state_r == S_IDLE && out_strobe_r)
    else $error("finished query did not return to idle with a result");

endmodule

/* sv/thick_polyline_pixel_test.sv */
// Top level of the thick polyline pixel test: configuration registers and wiring.
// Depends on tpp_pkg, tpp_store, tpp_dpath and tpp_seq.
//
// The block keeps up to MAX_POINTS polyline points and answers, for one output pixel,
// whether it lies within the draw radius of a stored point or of a segment joining two
// consecutive points of a stroke. An item is taken when start is high and busy is low.
// Load and clear items finish in the accepting cycle, give no result and leave busy low.
// A query item raises busy and is worked by one shared multiply-accumulate unit under a
// sequencer. Busy then stays high through setup and a walk over the stored points: each
// point is tested as a point, then, when it also closes a segment, the projection onto
// that segment is checked, and when the projection lands inside the segment, the
// distance to the segment is checked too. The walk stops at the first hit or at the end
// of the store. A pixel outside grid_size times scale ends the query after the range
// check. Each query yields exactly one result item, shown on out_data for one cycle with
// out_strobe high in the first cycle in which busy is low again; the receiver cannot
// stall it, so it must take the item in that cycle. Configuration writes are taken at
// once through cfg_we and should only be made while busy is low.
module thick_polyline_pixel_test #(
  parameter int MAX_POINTS = 256,
  parameter int MAX_GRID   = 64,
  parameter int MAX_SCALE  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  tpp_pkg::in_item_t                  in_data,
  output logic                               out_strobe,
  output tpp_pkg::out_item_t                 out_data,
  input  logic                               cfg_we,
  input  logic [tpp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tpp_pkg::CFG_W-1:0]          cfg_wdata
);
  import tpp_pkg::*;

  localparam int GW  = $clog2(MAX_GRID + 1);
  localparam int SW  = $clog2(MAX_SCALE + 1);
  localparam int CNW = $clog2(MAX_POINTS + 1);

  logic [GRID_W-1:0] grid_size_r;
  logic [SCL_W-1:0]  scale_r;
  logic [THK_W-1:0]  thickness_r;

  logic [GW-1:0]     g_sat;
  logic [SW-1:0]     s_sat;
  logic              accept;
  logic              capture;
  logic [CNW-1:0]    idx, cnt;
  pt_entry_t         rd_entry;
  uop_t              uop;
  flags_t            flags;

  // Configuration registers. Writes to an unused index are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_size_r <= GRID_W'(8);
      scale_r     <= SCL_W'(1);
      thickness_r <= THK_W'(16);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_GRID_SIZE: grid_size_r <= cfg_wdata[GRID_W-1:0];
        CFG_SCALE:     scale_r     <= cfg_wdata[SCL_W-1:0];
        CFG_THICKNESS: thickness_r <= cfg_wdata[THK_W-1:0];
        default:       ;
      endcase
    end
  end

  // Grid size and scale saturate into their legal ranges before use.
  always_comb begin
    priority if (grid_size_r == '0) begin
      g_sat = GW'(1);
    end else if (32'(grid_size_r) > 32'(MAX_GRID)) begin
      g_sat = GW'(MAX_GRID);
    end else begin
      g_sat = GW'(grid_size_r);
    end
    priority if (scale_r == '0) begin
      s_sat = SW'(1);
    end else if (32'(scale_r) > 32'(MAX_SCALE)) begin
      s_sat = SW'(MAX_SCALE);
    end else begin
      s_sat = SW'(scale_r);
    end
  end

  assign accept = start && !busy;

  tpp_store #(
    .MAX_POINTS(MAX_POINTS)
  ) u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .operation    (in_data.operation),
    .point_x      (in_data.point_x),
    .point_y      (in_data.point_y),
    .starts_stroke(in_data.starts_stroke),
    .rd_idx       (idx),
    .rd_entry     (rd_entry),
    .cnt          (cnt)
  );

  tpp_dpath #(
    .MAX_GRID (MAX_GRID),
    .MAX_SCALE(MAX_SCALE)
  ) u_dpath (
    .clk      (clk),
    .capture  (capture),
    .pixel_x  (in_data.pixel_x),
    .pixel_y  (in_data.pixel_y),
    .g        (g_sat),
    .s        (s_sat),
    .thickness(thickness_r),
    .rd_entry (rd_entry),
    .uop      (uop),
    .flags    (flags)
  );

  tpp_seq #(
    .MAX_POINTS(MAX_POINTS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .operation (in_data.operation),
    .cnt       (cnt),
    .rd_mark   (rd_entry.starts_stroke),
    .flags     (flags),
    .busy      (busy),
    .capture   (capture),
    .idx       (idx),
    .uop       (uop),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

endmodule
